// File: hdl/slab_free_list_allocator_unit_macros.svh
// Assertion macros for the slab free-list allocator.
// Depends on nothing; the using module supplies i_clk and i_rst_n.
`ifndef SLAB_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define SLAB_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sfla_pkg.sv
// Shared types, codes and constants of the slab free-list allocator.
// No dependencies.
package sfla_pkg;

    localparam int HANDLE_W      = 8;
    localparam int HEAD_W        = 9;
    localparam int HANDLE_SPACE  = 256;
    localparam logic [HEAD_W-1:0] LIST_END = 9'h100;
    localparam int CFG_W         = 6;
    localparam logic [CFG_W-1:0] SLAB_LIMIT_RESET = 6'd32;
    localparam int STATUS_W      = 2;

    localparam int DEF_ENTRIES_PER_SLAB = 8;
    localparam int DEF_MAX_SLABS        = 32;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_OOM        = 2'd1,
        STATUS_BAD_HANDLE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the request, next pointer read is under way
        logic pop;         // grant the head, advance it to its next pointer
        logic push;        // link the released handle in front of the head
        logic oom;         // report out of memory
        logic bad;         // report a bad handle
        logic link_write;  // write one next pointer of the new slab
        logic link_done;   // last write: count the slab and grant its first entry
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic head_empty;
        logic can_link;
        logic bad_handle;
        logic link_last;
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/sfla_if.sv
// Request and response channel interfaces of the slab free-list allocator.
// Depends on sfla_pkg for field widths.
interface sfla_req_if import sfla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [HANDLE_W-1:0] release_handle;

    modport source (output valid, output cmd, output release_handle, input ready);
    modport sink   (input valid, input cmd, input release_handle, output ready);
endinterface

interface sfla_rsp_if import sfla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] granted_handle;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_handle, output status, input ready);
    modport sink   (input valid, input granted_handle, input status, output ready);
endinterface

// File: hdl/sfla_ctrl.sv
// Controller state machine of the slab free-list allocator.
// Depends on sfla_pkg for states and the command/status structs.
module sfla_ctrl import sfla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && i_st.out_free) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_st.is_release && i_st.head_empty && i_st.can_link) begin
                    n_state = ST_LINK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LINK: begin
                if (i_st.link_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = i_st.out_free;
                o_cmd.capture = i_req_valid && i_st.out_free;
            end
            ST_EXEC: begin
                if (i_st.is_release) begin
                    o_cmd.bad  = i_st.bad_handle;
                    o_cmd.push = !i_st.bad_handle;
                end else begin
                    o_cmd.pop = !i_st.head_empty;
                    o_cmd.oom = i_st.head_empty && !i_st.can_link;
                end
            end
            ST_LINK: begin
                o_cmd.link_write = 1'b1;
                o_cmd.link_done  = i_st.link_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/sfla_dp.sv
// Datapath of the slab free-list allocator: head, slab count, next-pointer memory.
// Depends on sfla_pkg; driven by sfla_ctrl commands.
module sfla_dp import sfla_pkg::*; #(
    parameter int ENTRIES_PER_SLAB = DEF_ENTRIES_PER_SLAB,
    parameter int MAX_SLABS        = DEF_MAX_SLABS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_req_cmd,
    input  logic [HANDLE_W-1:0] i_req_handle,
    input  logic                i_rsp_ready,
    output logic                o_rsp_valid,
    output logic [HANDLE_W-1:0] o_granted,
    output logic [STATUS_W-1:0] o_status,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_st
);

    localparam int FIT   = HANDLE_SPACE / ENTRIES_PER_SLAB;
    localparam int SM_W  = $clog2(FIT + 1);
    localparam int CNT_W = (ENTRIES_PER_SLAB > 1) ? $clog2(ENTRIES_PER_SLAB) : 1;
    localparam int CMP_W = 10;

    logic [CFG_W-1:0]    r_slab_limit;
    logic [HEAD_W-1:0]   r_head;
    logic [SM_W-1:0]     r_slabs_made;
    logic [CNT_W-1:0]    r_link_cnt;
    logic                r_cmd;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_granted;
    logic [STATUS_W-1:0] r_status;

    logic [HEAD_W-1:0]   mem [HANDLE_SPACE];
    logic [HEAD_W-1:0]   r_rdata;

    logic [HEAD_W-1:0]   w_base;
    logic [HEAD_W-1:0]   w_link_addr;
    logic [HEAD_W-1:0]   w_link_data;
    logic [HEAD_W-1:0]   w_fresh_next;
    logic                w_we;
    logic [HANDLE_W-1:0] w_waddr;
    logic [HEAD_W-1:0]   w_wdata;
    logic                w_emit;

    assign w_base      = HEAD_W'(r_slabs_made) * HEAD_W'(ENTRIES_PER_SLAB);
    assign w_link_addr = w_base + HEAD_W'(r_link_cnt);
    assign w_link_data = o_st.link_last ? LIST_END : w_link_addr + HEAD_W'(1);
    assign w_fresh_next = (ENTRIES_PER_SLAB > 1) ? w_base + HEAD_W'(1) : LIST_END;

    assign o_st.is_release = (r_cmd == CMD_RELEASE);
    assign o_st.head_empty = r_head[HEAD_W-1];
    assign o_st.can_link   = (CMP_W'(r_slabs_made) < CMP_W'(r_slab_limit))
                          && (CMP_W'(r_slabs_made) < CMP_W'(MAX_SLABS))
                          && (CMP_W'(r_slabs_made) < CMP_W'(FIT));
    assign o_st.bad_handle = ({1'b0, r_handle} >= w_base);
    assign o_st.link_last  = (r_link_cnt == CNT_W'(ENTRIES_PER_SLAB - 1));
    assign o_st.out_free   = !r_out_valid || i_rsp_ready;

    // Memory write port: a push or a slab link-up, never both.
    assign w_we    = i_cmd.push || i_cmd.link_write;
    assign w_waddr = i_cmd.push ? r_handle : w_link_addr[HANDLE_W-1:0];
    assign w_wdata = i_cmd.push ? r_head : w_link_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[r_head[HANDLE_W-1:0]];
    end

    assign w_emit = i_cmd.pop || i_cmd.push || i_cmd.oom || i_cmd.bad || i_cmd.link_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slab_limit <= SLAB_LIMIT_RESET;
            r_head       <= LIST_END;
            r_slabs_made <= '0;
            r_link_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slab_limit <= i_cfg_wdata;
            end
            if (i_cmd.pop) begin
                r_head <= r_rdata;
            end else if (i_cmd.push) begin
                r_head <= {1'b0, r_handle};
            end else if (i_cmd.link_done) begin
                r_head <= w_fresh_next;
            end
            if (i_cmd.link_done) begin
                r_slabs_made <= r_slabs_made + SM_W'(1);
                r_link_cnt   <= '0;
            end else if (i_cmd.link_write) begin
                r_link_cnt <= r_link_cnt + CNT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: request capture and response fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_req_cmd;
            r_handle <= i_req_handle;
        end
        if (w_emit) begin
            priority if (i_cmd.pop) begin
                r_granted <= r_head[HANDLE_W-1:0];
                r_status  <= STATUS_OK;
            end else if (i_cmd.link_done) begin
                r_granted <= w_base[HANDLE_W-1:0];
                r_status  <= STATUS_OK;
            end else if (i_cmd.oom) begin
                r_granted <= '0;
                r_status  <= STATUS_OOM;
            end else if (i_cmd.bad) begin
                r_granted <= '0;
                r_status  <= STATUS_BAD_HANDLE;
            end else begin
                r_granted <= '0;
                r_status  <= STATUS_OK;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_granted   = r_granted;
    assign o_status    = r_status;

endmodule

// File: hdl/slab_free_list_allocator_unit.sv
// Top level of the slab free-list allocator: controller plus datapath.
// Depends on sfla_pkg, sfla_if, sfla_ctrl, sfla_dp and the assertion macros.
//
//  channel  | dir | payload                         | accepted when
//  ---------+-----+---------------------------------+-------------------------
//  i_req    | in  | cmd, release_handle             | valid && ready
//  o_rsp    | out | granted_handle, status          | valid && ready
//  cfg      | in  | i_cfg_wdata (slab_limit, 6 bit) | i_cfg_we
//
// One request is in flight at a time. The accept cycle issues the next-pointer
// read at the head; the execute state then pops or pushes through the single
// write port of the next-pointer memory. An allocate that finds the list empty
// links a fresh slab first, one entry per cycle. The response sits in an output
// register, so a new request is accepted while the previous response is taken in
// the same cycle. Synchronous active-low reset empties the list and zeroes the
// slab count; the next-pointer memory needs no clearing pass, every entry is
// written when its slab is linked.
`include "slab_free_list_allocator_unit_macros.svh"

module slab_free_list_allocator_unit import sfla_pkg::*; #(
    parameter int ENTRIES_PER_SLAB = DEF_ENTRIES_PER_SLAB,
    parameter int MAX_SLABS        = DEF_MAX_SLABS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sfla_req_if.sink         i_req,
    sfla_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_st;

    // Sequence each request: capture, execute, optional slab link-up.
    sfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    // Hold the free list, slab count, limit register and response register.
    sfla_dp #(
        .ENTRIES_PER_SLAB (ENTRIES_PER_SLAB),
        .MAX_SLABS        (MAX_SLABS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_cmd    (i_req.cmd),
        .i_req_handle (i_req.release_handle),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_granted    (o_rsp.granted_handle),
        .o_status     (o_rsp.status),
        .i_cmd        (w_cmd),
        .o_st         (w_st)
    );

    // Only one request in flight: no accept right after an accept.
    `SFLA_ASSERT_NEXT(a_one_in_flight, i_req.valid && i_req.ready, !i_req.ready, "second request accepted while one is in flight")
    // An accept never lands on a response that is still pending.
    `SFLA_ASSERT_NEXT(a_no_overwrite, i_req.valid && i_req.ready, !o_rsp.valid, "response register busy after accept")
    // Failed requests grant nothing.
    `SFLA_ASSERT_NOW(a_fail_zero, o_rsp.valid && (o_rsp.status != STATUS_OK), o_rsp.granted_handle == '0, "non-zero handle on failed request")

endmodule

// File: dv/tb_slab_free_list_allocator_unit.sv
// Self-checking testbench of the slab free-list allocator.
// Holds its own free-list predictor and drives requests and checks responses.
// Depends on sfla_pkg, sfla_if and slab_free_list_allocator_unit.
`timescale 1ns / 1ps

module tb_slab_free_list_allocator_unit;
    import sfla_pkg::*;

    localparam int SLAB_SIZE   = DEF_ENTRIES_PER_SLAB;
    localparam int SLAB_CEIL   = DEF_MAX_SLABS;
    localparam int CYCLE_LIMIT = 200000;
    // Two copies of the free list: one advanced when a request is accepted,
    // one advanced when the request is queued, so that stimulus can pick held
    // handles for well-formed releases.
    localparam int LIVE = 0;
    localparam int PLAN = 1;

    typedef struct packed {
        t_cmd                cmd;
        logic [HANDLE_W-1:0] handle;
    } t_alloc_request;

    typedef struct packed {
        logic [HANDLE_W-1:0] granted;
        t_status             status;
    } t_alloc_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    sfla_req_if req_if ();
    sfla_rsp_if rsp_if ();

    slab_free_list_allocator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predicted allocator state.
    logic [HEAD_W-1:0] pool_head [0:1];
    logic [HEAD_W-1:0] pool_next [0:1][0:HANDLE_SPACE-1];
    int                pool_slabs [0:1];
    int                slab_limit_q;

    t_alloc_request      pending_requests [$];
    t_alloc_result       expected_results [$];
    logic [HANDLE_W-1:0] held_handles [$];

    int   requests_open;
    int   mismatches;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic req_taken;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count++;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Pop or push one request on the chosen copy of the free list; an
    // allocate on an empty list links a fresh slab first if the cap allows.
    function automatic void serve_request(input int copy, input t_cmd cmd,
                                          input logic [HANDLE_W-1:0] handle,
                                          output logic [HANDLE_W-1:0] granted,
                                          output t_status status);
        int cap;
        int base;
        int i;
        cap = slab_limit_q;
        if (cap > SLAB_CEIL)
            cap = SLAB_CEIL;
        if (cap > HANDLE_SPACE / SLAB_SIZE)
            cap = HANDLE_SPACE / SLAB_SIZE;
        granted = '0;
        status  = STATUS_OK;
        if (cmd == CMD_ALLOC) begin
            if (pool_head[copy] >= LIST_END && pool_slabs[copy] < cap) begin
                base = pool_slabs[copy] * SLAB_SIZE;
                for (i = 0; i < SLAB_SIZE - 1; i++)
                    pool_next[copy][base + i] = HEAD_W'(base + i + 1);
                pool_next[copy][base + SLAB_SIZE - 1] = LIST_END;
                pool_head[copy] = HEAD_W'(base);
                pool_slabs[copy]++;
            end
            if (pool_head[copy] >= LIST_END) begin
                status = STATUS_OOM;
            end else begin
                granted         = pool_head[copy][HANDLE_W-1:0];
                pool_head[copy] = pool_next[copy][granted];
            end
        end else if (int'(handle) >= pool_slabs[copy] * SLAB_SIZE) begin
            status = STATUS_BAD_HANDLE;
        end else begin
            pool_next[copy][handle] = pool_head[copy];
            pool_head[copy]         = {1'b0, handle};
        end
    endfunction

    // Response check first (it belongs to the previous request), then the
    // prediction for a request accepted at this edge.
    always @(posedge i_clk) begin : monitor
        t_alloc_result       want;
        logic [HANDLE_W-1:0] granted;
        t_status             status;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("response %0d/%0d with no request open",
                                              rsp_if.granted_handle, rsp_if.status));
                end else begin
                    want = expected_results.pop_front();
                    requests_open--;
                    if (rsp_if.granted_handle !== want.granted)
                        report_mismatch($sformatf("granted handle %0d, predicted %0d",
                                                  rsp_if.granted_handle, want.granted));
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("status code %0d, predicted %0d",
                                                  rsp_if.status, want.status));
                end
            end
            if (req_if.valid && req_if.ready) begin
                serve_request(LIVE, t_cmd'(req_if.cmd), req_if.release_handle, granted, status);
                expected_results.push_back('{granted, status});
                req_taken = 1'b1;
            end
        end
    end

    // Hold a request until it is taken, then advance to the next one unless
    // the sender idles this cycle. Ready toggles at random on its own.
    always @(negedge i_clk) begin : driver
        t_alloc_request next_req;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (req_if.valid && !req_taken) begin
                // hold
            end else if (pending_requests.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                req_if.valid          <= 1'b1;
                req_if.cmd            <= next_req.cmd;
                req_if.release_handle <= next_req.handle;
            end else begin
                req_if.valid <= 1'b0;
            end
            req_taken = 1'b0;
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_request(input t_cmd cmd, input logic [HANDLE_W-1:0] handle);
        logic [HANDLE_W-1:0] granted;
        t_status             status;
        serve_request(PLAN, cmd, handle, granted, status);
        if (cmd == CMD_ALLOC && status == STATUS_OK)
            held_handles.push_back(granted);
        requests_open++;
        pending_requests.push_back('{cmd, handle});
    endtask

    // Mostly well-formed traffic: allocates and releases of held handles,
    // with a tenth of raw noise (random allocates, stray, bad and double releases).
    task automatic queue_random(input int count, input int alloc_pct);
        int                  k;
        int                  idx;
        logic [HANDLE_W-1:0] handle;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 10) begin
                queue_request(t_cmd'($urandom_range(1)), HANDLE_W'($urandom_range(255)));
            end else if (held_handles.size() == 0 || $urandom_range(99) < alloc_pct) begin
                queue_request(CMD_ALLOC, HANDLE_W'($urandom_range(255)));
            end else begin
                idx    = $urandom_range(held_handles.size() - 1);
                handle = held_handles[idx];
                held_handles.delete(idx);
                queue_request(CMD_RELEASE, handle);
            end
        end
    endtask

    // Every request yields a response, so an empty count means idle.
    task automatic wait_quiet();
        while (requests_open != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_slab_limit(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        slab_limit_q = value;
    endtask

    initial begin : stimulus
        int c;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        req_if.valid          = 1'b0;
        req_if.cmd            = CMD_ALLOC;
        req_if.release_handle = '0;
        rsp_if.ready          = 1'b0;
        req_taken             = 1'b0;
        requests_open         = 0;
        mismatches            = 0;
        cycle_count           = 0;
        send_idle_pct         = 9;
        recv_idle_pct         = 51;
        slab_limit_q          = SLAB_LIMIT_RESET;
        for (c = LIVE; c <= PLAN; c++) begin
            pool_head[c]  = LIST_END;
            pool_slabs[c] = 0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero limit: nothing can be made, every handle is bad.
        write_slab_limit(6'd0);
        queue_request(CMD_ALLOC, 8'h00);
        queue_request(CMD_RELEASE, 8'h00);
        queue_request(CMD_RELEASE, 8'hFF);
        wait_quiet();

        // One slab: drain it, overrun it, then check LIFO order on release.
        write_slab_limit(6'd1);
        repeat (SLAB_SIZE + 1) queue_request(CMD_ALLOC, 8'hFF);
        queue_request(CMD_RELEASE, 8'd8);
        queue_request(CMD_RELEASE, 8'd7);
        queue_request(CMD_RELEASE, 8'd0);
        queue_request(CMD_ALLOC, 8'h00);
        queue_request(CMD_ALLOC, 8'h00);
        wait_quiet();

        // Limit lowered below the slabs already made: old slab stays usable.
        write_slab_limit(6'd0);
        queue_request(CMD_RELEASE, 8'd3);
        queue_request(CMD_ALLOC, 8'h00);
        queue_request(CMD_ALLOC, 8'h00);
        wait_quiet();

        write_slab_limit(SLAB_LIMIT_RESET);
        queue_request(CMD_ALLOC, 8'h00);
        wait_quiet();

        // Small cap, mixed traffic, sender mostly busy.
        write_slab_limit(6'd4);
        queue_random(300, 50);
        wait_quiet();

        // Cap above the handle space: allocate heavily until every handle is out.
        send_idle_pct = 51;
        recv_idle_pct = 9;
        write_slab_limit(6'd63);
        queue_random(360, 97);
        wait_quiet();

        // Lower the cap again and run without idling.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_slab_limit(6'd2);
        queue_random(300, 45);
        wait_quiet();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/sfla_pkg.sv
hdl/sfla_if.sv
hdl/sfla_ctrl.sv
hdl/sfla_dp.sv
hdl/slab_free_list_allocator_unit.sv
dv/tb_slab_free_list_allocator_unit.sv
